>>> rtl/dsp_pkg.sv
// dsp_pkg: shared constants and types for the shortest-path block
// used by every file under rtl but dsp_if
`default_nettype none
package dsp_pkg;
  localparam int unsigned MaxVertices = 64;
  localparam int unsigned MaxEdges    = 256;
  localparam int unsigned WeightBits  = 16;
  localparam int unsigned VtxW  = $clog2(MaxVertices);
  localparam int unsigned CntW  = $clog2(MaxVertices + 1);
  localparam int unsigned EdgeW = $clog2(MaxEdges);
  localparam int unsigned ECntW = $clog2(MaxEdges + 1);
  localparam int unsigned DistW = 30;
  localparam logic [DistW-1:0] Unreachable = 30'h3f3f3f3f;

  typedef enum logic [1:0] {
    OpAddEdge = 2'd0,
    OpSolve   = 2'd1,
    OpClear   = 2'd2,
    OpNone    = 2'd3
  } op_e;

  typedef struct packed {
    logic             init;   // load infinity, seed source
    logic [VtxW-1:0]  src;
    logic             src_ok;
    logic             relax;  // relax one edge this cycle
    logic [VtxW-1:0]  tail;
    logic [VtxW-1:0]  head;
    logic [DistW-1:0] sum;    // saturated candidate
    logic             pick;   // finalize chosen vertex
    logic [VtxW-1:0]  best;
    logic             shift;  // rotate chain for scan/output
  } cell_ctrl_t;

  typedef struct packed {
    logic [DistW-1:0] cost;
    logic [VtxW-1:0]  pred;
    logic             pvalid;
    logic             fin;
  } cell_state_t;
endpackage
`default_nettype wire

>>> rtl/dsp_if.sv
// dsp_if: valid/ready channels for items and results
// depends on no other file
`default_nettype none
interface dsp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [5:0] edge_from;
  logic [5:0] edge_to;
  logic [15:0] edge_weight;
  logic [5:0] source_vertex;
  modport source (output valid, operation, edge_from, edge_to, edge_weight,
                  source_vertex, input ready);
  modport sink (input valid, operation, edge_from, edge_to, edge_weight,
                source_vertex, output ready);
endinterface

interface dsp_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  vertex_id;
  logic [29:0] distance;
  logic [5:0]  predecessor;
  logic        has_predecessor;
  logic        edge_overflow;
  logic        last;
  modport source (output valid, vertex_id, distance, predecessor, has_predecessor,
                  edge_overflow, last, input ready);
  modport sink (input valid, vertex_id, distance, predecessor, has_predecessor,
                edge_overflow, last, output ready);
endinterface
`default_nettype wire

>>> rtl/dsp_cell.sv
// dsp_cell: one vertex cell of the distance chain
// depends on dsp_pkg; cells pass their state to the neighbour on a shift
`default_nettype none
module dsp_cell (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire logic [dsp_pkg::VtxW-1:0] id_i,
  input  wire dsp_pkg::cell_ctrl_t      ctrl_i,
  input  wire dsp_pkg::cell_state_t     prev_i,
  output dsp_pkg::cell_state_t          state_o
);
  dsp_pkg::cell_state_t st_q, st_d;

  always_comb begin
    st_d = st_q;
    if (ctrl_i.init) begin
      st_d.cost   = (ctrl_i.src_ok && ctrl_i.src == id_i) ? '0 : dsp_pkg::Unreachable;
      st_d.pred   = '0;
      st_d.pvalid = 1'b0;
      st_d.fin    = 1'b0;
    end else if (ctrl_i.shift) begin
      st_d = prev_i;
    end else begin
      if (ctrl_i.pick && ctrl_i.best == id_i) st_d.fin = 1'b1;
      if (ctrl_i.relax && ctrl_i.head == id_i && !st_q.fin && st_q.cost > ctrl_i.sum) begin
        st_d.cost   = ctrl_i.sum;
        st_d.pred   = ctrl_i.tail;
        st_d.pvalid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{cost: dsp_pkg::Unreachable, pred: '0, pvalid: 1'b0, fin: 1'b1};
    end else begin
      st_q <= st_d;
    end
  end

  assign state_o = st_q;
endmodule
`default_nettype wire

>>> rtl/dsp_chain.sv
// dsp_chain: ring of vertex cells; cell k always holds vertex (k + rot) mod MaxVertices
// depends on dsp_pkg and dsp_cell
`default_nettype none
module dsp_chain (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire logic [dsp_pkg::VtxW-1:0] rot_i,
  input  wire dsp_pkg::cell_ctrl_t      ctrl_i,
  output dsp_pkg::cell_state_t          head_o
);
  dsp_pkg::cell_state_t st [dsp_pkg::MaxVertices];
  dsp_pkg::cell_ctrl_t  cc;

  // cells are addressed by physical slot; translate head and best ids by rotation
  always_comb begin
    cc      = ctrl_i;
    cc.src  = ctrl_i.src;
    cc.head = ctrl_i.head - rot_i;
    cc.best = ctrl_i.best - rot_i;
  end

  for (genvar k = 0; k < dsp_pkg::MaxVertices; k++) begin : g_cell
    dsp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .id_i    (dsp_pkg::VtxW'(k)),
      .ctrl_i  (cc),
      .prev_i  (st[(k + 1) % dsp_pkg::MaxVertices]),
      .state_o (st[k])
    );
  end

  assign head_o = st[0];
endmodule
`default_nettype wire

>>> rtl/dijkstra_shortest_paths.sv
// dijkstra_shortest_paths: top level, edge memory and solve sequencer
// depends on dsp_pkg, dsp_if, dsp_chain
//
//  channel  dir  handshake    payload
//  in_if    in   valid/ready  operation, edges, source_vertex
//  out_if   out  valid/ready  one result per vertex
//  cfg      in   cfg_we_i     vertex_count
//
// add edge and clear are handled in the idle state without leaving it.
// solve: an init step, then per round a min scan (the chain rotating past the
// chain head one cell a cycle, then a finalize step) plus relaxation over every
// stored edge on the one-read-port edge memory, one round per reachable vertex and
// a last scan that finds none; then one result per vertex in use.
// results stall the output rotation only; no item is taken during a solve.
`default_nettype none
module dijkstra_shortest_paths (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  cfg_we_i,
  input  wire  [6:0]           cfg_wdata_i,
  dsp_in_if.sink               in_if,
  dsp_out_if.source            out_if
);
  localparam int unsigned VW = dsp_pkg::VtxW;

  typedef enum logic [2:0] {StIdle, StInit, StScan, StRelax, StOut} state_e;
  state_e state_q;

  logic [6:0] vc_q;
  logic [dsp_pkg::CntW-1:0] nv;
  assign nv = (vc_q == '0) ? dsp_pkg::CntW'(1) :
              (vc_q > 7'(dsp_pkg::MaxVertices)) ? dsp_pkg::CntW'(dsp_pkg::MaxVertices) :
              dsp_pkg::CntW'(vc_q);

  logic [VW-1:0] tail_mem [dsp_pkg::MaxEdges];
  logic [VW-1:0] head_mem [dsp_pkg::MaxEdges];
  logic [dsp_pkg::WeightBits-1:0] wt_mem [dsp_pkg::MaxEdges];
  logic [dsp_pkg::ECntW-1:0] ecnt_q;
  logic ovf_q;

  logic [VW-1:0] rot_q;        // vertex at chain head
  logic [VW:0]   scnt_q;       // cells swept
  logic [dsp_pkg::ECntW-1:0] eidx_q;
  logic          rd_v_q;       // edge read in flight
  logic [VW-1:0] rd_t_q, rd_h_q;
  logic [dsp_pkg::WeightBits-1:0] rd_w_q;
  logic [VW-1:0] best_q;
  logic [dsp_pkg::DistW-1:0] bestd_q;
  logic          found_q;
  logic [VW-1:0] src_q;
  logic          src_ok_q;

  dsp_pkg::cell_state_t hd;
  dsp_pkg::cell_ctrl_t  ctrl;

  logic in_acc, out_acc;
  assign in_if.ready = (state_q == StIdle);
  assign in_acc = in_if.valid && in_if.ready;
  assign out_acc = out_if.valid && out_if.ready;

  logic [dsp_pkg::DistW:0] wsum;
  assign wsum = {1'b0, bestd_q} + (dsp_pkg::DistW+1)'(rd_w_q);

  always_comb begin
    ctrl = '0;
    ctrl.init   = (state_q == StInit);
    ctrl.src    = src_q;
    ctrl.src_ok = src_ok_q;
    ctrl.relax  = (state_q == StRelax) && rd_v_q && rd_t_q == best_q &&
                  dsp_pkg::CntW'(rd_h_q) < nv;
    ctrl.tail   = best_q;
    ctrl.head   = rd_h_q;
    ctrl.sum    = (wsum > {1'b0, dsp_pkg::Unreachable}) ? dsp_pkg::Unreachable :
                  wsum[dsp_pkg::DistW-1:0];
    ctrl.pick   = (state_q == StScan) && scnt_q == (VW+1)'(dsp_pkg::MaxVertices) && found_q;
    ctrl.best   = best_q;
    ctrl.shift  = (state_q == StScan && scnt_q < (VW+1)'(dsp_pkg::MaxVertices)) ||
                  (state_q == StOut && out_acc);
  end

  dsp_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rot_i  (rot_q),
    .ctrl_i (ctrl),
    .head_o (hd)
  );

  always_ff @(posedge clk_i) begin
    if (in_acc && in_if.operation == dsp_pkg::OpAddEdge && ecnt_q < dsp_pkg::ECntW'(dsp_pkg::MaxEdges)
        && dsp_pkg::CntW'(in_if.edge_from) < nv && dsp_pkg::CntW'(in_if.edge_to) < nv) begin
      tail_mem[ecnt_q[dsp_pkg::EdgeW-1:0]] <= in_if.edge_from;
      head_mem[ecnt_q[dsp_pkg::EdgeW-1:0]] <= in_if.edge_to;
      wt_mem[ecnt_q[dsp_pkg::EdgeW-1:0]]   <= in_if.edge_weight[dsp_pkg::WeightBits-1:0];
    end
    rd_t_q <= tail_mem[eidx_q[dsp_pkg::EdgeW-1:0]];
    rd_h_q <= head_mem[eidx_q[dsp_pkg::EdgeW-1:0]];
    rd_w_q <= wt_mem[eidx_q[dsp_pkg::EdgeW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; vc_q <= 7'd64; ecnt_q <= '0; ovf_q <= 1'b0;
      rot_q <= '0; scnt_q <= '0; eidx_q <= '0; rd_v_q <= 1'b0;
      best_q <= '0; bestd_q <= '0; found_q <= 1'b0; src_q <= '0; src_ok_q <= 1'b0;
    end else begin
      if (cfg_we_i) vc_q <= cfg_wdata_i;
      unique case (state_q)
        StIdle: if (in_acc) begin
          unique case (dsp_pkg::op_e'(in_if.operation))
            dsp_pkg::OpAddEdge:
              if (ecnt_q >= dsp_pkg::ECntW'(dsp_pkg::MaxEdges) ||
                  dsp_pkg::CntW'(in_if.edge_from) >= nv ||
                  dsp_pkg::CntW'(in_if.edge_to) >= nv) ovf_q <= 1'b1;
              else ecnt_q <= ecnt_q + 1'b1;
            dsp_pkg::OpClear: begin ecnt_q <= '0; ovf_q <= 1'b0; end
            dsp_pkg::OpSolve: begin
              src_q <= in_if.source_vertex;
              src_ok_q <= dsp_pkg::CntW'(in_if.source_vertex) < nv;
              state_q <= StInit;
            end
            default: ;
          endcase
        end
        StInit: begin
          rot_q <= '0; scnt_q <= '0; found_q <= 1'b0; bestd_q <= dsp_pkg::Unreachable;
          state_q <= StScan;
        end
        StScan: begin
          if (scnt_q < (VW+1)'(dsp_pkg::MaxVertices)) begin
            // candidate: lower id wins ties since ids rise along the sweep
            if (dsp_pkg::CntW'(rot_q) < nv && !hd.fin && hd.cost < bestd_q) begin
              bestd_q <= hd.cost; best_q <= rot_q; found_q <= 1'b1;
            end
            rot_q <= rot_q + 1'b1;
            scnt_q <= scnt_q + 1'b1;
          end else if (found_q) begin
            eidx_q <= '0; rd_v_q <= 1'b0;
            state_q <= StRelax;
          end else begin
            scnt_q <= '0;
            state_q <= StOut;
          end
        end
        StRelax: begin
          rd_v_q <= eidx_q < ecnt_q;
          eidx_q <= eidx_q + 1'b1;
          if (!(eidx_q < ecnt_q) && !rd_v_q) begin
            scnt_q <= '0; found_q <= 1'b0; bestd_q <= dsp_pkg::Unreachable;
            state_q <= StScan;
          end
        end
        StOut: if (out_acc) begin
          rot_q <= rot_q + 1'b1;
          if (dsp_pkg::CntW'(rot_q) + 1'b1 == nv) state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_if.valid           = (state_q == StOut);
  assign out_if.vertex_id       = rot_q;
  assign out_if.distance        = hd.cost;
  assign out_if.predecessor     = hd.pvalid ? hd.pred : '0;
  assign out_if.has_predecessor = hd.pvalid;
  assign out_if.edge_overflow   = ovf_q;
  assign out_if.last            = dsp_pkg::CntW'(rot_q) + 1'b1 == nv;

`ifndef SYNTH
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != StIdle |-> !in_if.ready) else $error("item taken during solve");
  a_out_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_if.valid) |-> rot_q == '0) else $error("output not from vertex 0");
  a_ecnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ecnt_q <= dsp_pkg::ECntW'(dsp_pkg::MaxEdges)) else $error("edge count overrun");
`endif
endmodule
`default_nettype wire

>>> tb/tb_dijkstra_shortest_paths.sv
// tb_dijkstra_shortest_paths: self-checking bench for the shortest-path block
// depends on dsp_pkg, dsp_if and the rtl top; drives edge, solve, clear and none
// items, predicts every per-vertex result and checks them in order
`default_nettype none
module tb_dijkstra_shortest_paths;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [5:0]  vid;
    logic [29:0] cost;
    logic [5:0]  pred;
    logic        has_pred;
    logic        ovf;
    logic        last;
  } vertex_res_t;

  typedef struct {
    dsp_pkg::op_e op;
    logic [5:0]  from;
    logic [5:0]  to;
    logic [15:0] weight;
    logic [5:0]  src;
    bit          typed;
    logic [5:0]  typed_vid;
    logic [29:0] typed_dist;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [6:0] cfg_wdata_i = '0;

  dsp_in_if  in_if ();
  dsp_out_if out_if ();

  dijkstra_shortest_paths i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  always #2 clk_i = ~clk_i;

  // predictor copy of the block state
  logic [5:0]  pm_tail [dsp_pkg::MaxEdges];
  logic [5:0]  pm_head [dsp_pkg::MaxEdges];
  logic [15:0] pm_weight [dsp_pkg::MaxEdges];
  int unsigned pm_edges;
  bit          pm_ovf;
  logic [6:0]  pm_vcount;

  vertex_res_t pending_paths[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned solves_sent;
  int unsigned items_sent;
  bit          idle_on;
  bit          long_hold_done = 1'b0;
  int unsigned hold_cnt = 0;
  int unsigned burst_cnt = 0;

  bit          typed_on;
  logic [5:0]  typed_vid;
  logic [29:0] typed_dist;

  function automatic int unsigned active_count();
    if (pm_vcount < 1) return 1;
    if (pm_vcount > dsp_pkg::MaxVertices) return dsp_pkg::MaxVertices;
    return pm_vcount;
  endfunction

  function automatic void predict_paths(logic [5:0] src);
    longint unsigned cost_of [dsp_pkg::MaxVertices];
    logic [5:0]      pred [dsp_pkg::MaxVertices];
    bit              pv [dsp_pkg::MaxVertices];
    bit              fin [dsp_pkg::MaxVertices];
    int unsigned     nv;
    int unsigned     best;
    longint unsigned bestd;
    longint unsigned sum;
    vertex_res_t     r;
    nv = active_count();
    for (int i = 0; i < dsp_pkg::MaxVertices; i++) begin
      cost_of[i] = dsp_pkg::Unreachable;
      pred[i] = '0;
      pv[i] = 1'b0;
      fin[i] = 1'b0;
    end
    if (src < nv) begin
      cost_of[src] = 0;
      forever begin
        best = nv;
        bestd = dsp_pkg::Unreachable;
        for (int i = 0; i < nv; i++)
          if (!fin[i] && cost_of[i] < bestd) begin
            bestd = cost_of[i];
            best = i;
          end
        if (best >= nv) break;
        fin[best] = 1'b1;
        for (int e = 0; e < pm_edges; e++) begin
          if (pm_tail[e] != best || pm_head[e] >= nv) continue;
          if (fin[pm_head[e]]) continue;
          sum = bestd + pm_weight[e];
          if (sum > dsp_pkg::Unreachable) sum = dsp_pkg::Unreachable;
          if (cost_of[pm_head[e]] > sum) begin
            cost_of[pm_head[e]] = sum;
            pred[pm_head[e]] = best[5:0];
            pv[pm_head[e]] = 1'b1;
          end
        end
      end
    end
    for (int i = 0; i < nv; i++) begin
      r.vid = i[5:0];
      r.cost = cost_of[i][29:0];
      r.pred = pv[i] ? pred[i] : 6'd0;
      r.has_pred = pv[i];
      r.ovf = pm_ovf;
      r.last = (i + 1 == nv);
      // hand-written value overrides the predictor for that vertex
      if (typed_on && typed_vid == i) r.cost = typed_dist;
      pending_paths.insert(pending_paths.size(), r);
    end
  endfunction

  function automatic void predict_item(dsp_pkg::op_e op, logic [5:0] from, logic [5:0] to,
                                       logic [15:0] weight, logic [5:0] src);
    int unsigned nv;
    nv = active_count();
    case (op)
      dsp_pkg::OpAddEdge: begin
        if (pm_edges >= dsp_pkg::MaxEdges || from >= nv || to >= nv) begin
          pm_ovf = 1'b1;
        end else begin
          pm_tail[pm_edges] = from;
          pm_head[pm_edges] = to;
          pm_weight[pm_edges] = weight;
          pm_edges++;
        end
      end
      dsp_pkg::OpSolve: predict_paths(src);
      dsp_pkg::OpClear: begin
        pm_edges = 0;
        pm_ovf = 1'b0;
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
    $display("mismatch %s: got %0h want %0h (result %0d)", field, got, want, results_seen);
    mismatches++;
  endtask

  // result monitor
  always @(posedge clk_i) begin
    vertex_res_t w;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (pending_paths.size() == 0) begin
        report_mismatch("unexpected transaction", out_if.vertex_id, 0);
      end else begin
        w = pending_paths.pop_front();
        if (out_if.vertex_id !== w.vid) report_mismatch("vertex_id", out_if.vertex_id, w.vid);
        if (out_if.distance !== w.cost) report_mismatch("distance", out_if.distance, w.cost);
        if (out_if.predecessor !== w.pred)
          report_mismatch("predecessor", out_if.predecessor, w.pred);
        if (out_if.has_predecessor !== w.has_pred)
          report_mismatch("has_predecessor", out_if.has_predecessor, w.has_pred);
        if (out_if.edge_overflow !== w.ovf)
          report_mismatch("edge_overflow", out_if.edge_overflow, w.ovf);
        if (out_if.last !== w.last) report_mismatch("last", out_if.last, w.last);
      end
    end
  end

  // result receiver with random back-pressure and one long hold-off
  always @(posedge clk_i) begin
    if (!long_hold_done && results_seen >= 70) begin
      long_hold_done <= 1'b1;
      hold_cnt <= 400;
      out_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_if.ready <= 1'b0;
    end else if (burst_cnt > 0) begin
      burst_cnt <= burst_cnt - 1;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      burst_cnt <= $urandom_range(0, 3);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task automatic send_item(dsp_pkg::op_e op, logic [5:0] from, logic [5:0] to,
                           logic [15:0] weight, logic [5:0] src);
    in_if.valid <= 1'b1;
    in_if.operation <= op;
    in_if.edge_from <= from;
    in_if.edge_to <= to;
    in_if.edge_weight <= weight;
    in_if.source_vertex <= src;
    do @(posedge clk_i); while (!in_if.ready);
    predict_item(op, from, to, weight, src);
    items_sent++;
    if (op == dsp_pkg::OpSolve) solves_sent++;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic set_vertex_count(logic [6:0] value);
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_paths.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    pm_vcount = value;
  endtask

  task automatic random_items(int unsigned n, int unsigned vmax);
    int unsigned r;
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 70)
        send_item(dsp_pkg::OpAddEdge, 6'($urandom_range(0, vmax)),
                  6'($urandom_range(0, vmax)), 16'($urandom), 6'($urandom));
      else if (r < 85)
        send_item(dsp_pkg::OpSolve, 6'($urandom), 6'($urandom), 16'($urandom),
                  6'($urandom_range(0, vmax)));
      else if (r < 93)
        send_item(dsp_pkg::OpClear, 6'($urandom), 6'($urandom), 16'($urandom),
                  6'($urandom));
      else
        send_item(dsp_pkg::OpNone, 6'($urandom), 6'($urandom), 16'($urandom),
                  6'($urandom));
    end
  endtask

  dir_row_t directed [16] = '{
    '{dsp_pkg::OpSolve,   6'd0,  6'd0,  16'd0,    6'd0,  1, 6'd1, dsp_pkg::Unreachable},
    '{dsp_pkg::OpAddEdge, 6'd0,  6'd1,  16'hffff, 6'd0,  0, 6'd0, 30'd0},
    '{dsp_pkg::OpAddEdge, 6'd1,  6'd2,  16'd0,    6'd0,  0, 6'd0, 30'd0},
    '{dsp_pkg::OpAddEdge, 6'd63, 6'd63, 16'd5,    6'd0,  0, 6'd0, 30'd0},
    '{dsp_pkg::OpAddEdge, 6'd2,  6'd0,  16'd0,    6'd0,  0, 6'd0, 30'd0},
    '{dsp_pkg::OpAddEdge, 6'd0,  6'd2,  16'hffff, 6'd0,  0, 6'd0, 30'd0},
    '{dsp_pkg::OpAddEdge, 6'd0,  6'd3,  16'd1,    6'd0,  0, 6'd0, 30'd0},
    '{dsp_pkg::OpAddEdge, 6'd3,  6'd2,  16'hfffe, 6'd0,  0, 6'd0, 30'd0},
    '{dsp_pkg::OpNone,    6'd63, 6'd63, 16'hffff, 6'd63, 0, 6'd0, 30'd0},
    '{dsp_pkg::OpSolve,   6'd0,  6'd0,  16'd0,    6'd0,  1, 6'd1, 30'd65535},
    '{dsp_pkg::OpSolve,   6'd0,  6'd0,  16'd0,    6'd0,  1, 6'd3, 30'd1},
    '{dsp_pkg::OpSolve,   6'd0,  6'd0,  16'd0,    6'd63, 1, 6'd0, dsp_pkg::Unreachable},
    '{dsp_pkg::OpAddEdge, 6'd63, 6'd0,  16'd7,    6'd0,  0, 6'd0, 30'd0},
    '{dsp_pkg::OpSolve,   6'd0,  6'd0,  16'd0,    6'd63, 1, 6'd63, 30'd0},
    '{dsp_pkg::OpClear,   6'd0,  6'd0,  16'd0,    6'd0,  0, 6'd0, 30'd0},
    '{dsp_pkg::OpSolve,   6'h3f, 6'h3f, 16'hffff, 6'd2,  1, 6'd1, dsp_pkg::Unreachable}
  };

  initial begin
    in_if.valid = 1'b0;
    in_if.operation = dsp_pkg::OpNone;
    in_if.edge_from = '0;
    in_if.edge_to = '0;
    in_if.edge_weight = '0;
    in_if.source_vertex = '0;
    pm_edges = 0;
    pm_ovf = 1'b0;
    pm_vcount = 7'd64;
    solves_sent = 0;
    items_sent = 0;
    idle_on = 1'b1;
    typed_on = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) begin
      typed_on = directed[i].typed;
      typed_vid = directed[i].typed_vid;
      typed_dist = directed[i].typed_dist;
      send_item(directed[i].op, directed[i].from, directed[i].to,
                directed[i].weight, directed[i].src);
      typed_on = 1'b0;
    end

    // fill the edge store past capacity, then solve on a full store
    for (int k = 0; k < dsp_pkg::MaxEdges + 3; k++)
      send_item(dsp_pkg::OpAddEdge, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                16'($urandom), 6'd0);
    send_item(dsp_pkg::OpSolve, 6'd0, 6'd0, 16'd0, 6'($urandom_range(0, 63)));
    send_item(dsp_pkg::OpClear, 6'd0, 6'd0, 16'd0, 6'd0);

    set_vertex_count(7'd5);
    random_items(30, 7);
    set_vertex_count(7'd0);
    random_items(10, 3);
    set_vertex_count(7'd127);
    send_item(dsp_pkg::OpClear, 6'd0, 6'd0, 16'd0, 6'd0);
    random_items(20, 63);
    // shrink the graph with wide edges still stored
    set_vertex_count(7'd8);
    for (int k = 0; k < 6; k++)
      send_item(dsp_pkg::OpSolve, 6'd0, 6'd0, 16'd0, 6'($urandom_range(0, 9)));
    random_items(20, 9);
    set_vertex_count(7'd64);
    idle_on = 1'b0;
    random_items(40, 63);
    in_if.valid <= 1'b0;

    while (pending_paths.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("covered %0d items, %0d solves and %0d checked vertex results", items_sent,
             solves_sent, results_seen);
    $display("vertex counts 64, 5, 0, 127, 8 with a full store and a long output stall");
    if (mismatches == 0 && pending_paths.size() == 0) begin
      $display("PASS dijkstra_shortest_paths");
    end else begin
      $display("FAIL dijkstra_shortest_paths");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAIL dijkstra_shortest_paths");
    $finish;
  end
endmodule
`default_nettype wire
